// File: hdl/ipow_pkg.sv
`timescale 1ns / 1ps

package ipow_pkg;

    localparam int DATA_W_MAX = 64;
    localparam int EXP_W_MAX  = 32;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int EXP_WIDTH_DEF  = 32;

    typedef struct packed {
        logic signed [DATA_W_MAX-1:0] base_value;
        logic signed [EXP_W_MAX-1:0]  exponent;
    } arg_t;

    typedef struct packed {
        logic signed [DATA_W_MAX-1:0] power;
        logic                         zero_pow_zero;
    } result_t;

    // partial product step of one wrapped multiply
    typedef enum logic [1:0] {
        PH_LO_LO = 2'd0,
        PH_LO_HI = 2'd1,
        PH_HI_LO = 2'd2,
        PH_WRITE = 2'd3
    } mul_phase_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        mul_phase_t phase;
        logic       dst_res;
        logic       shift_exp;
        logic       finish;
    } ipow_cmd_t;

    typedef struct packed {
        logic special;
        logic exp_zero;
        logic exp_lsb;
    } ipow_status_t;

endpackage

// File: hdl/ipow_datapath.sv
`timescale 1ns / 1ps

module ipow_datapath #(
    parameter int DATA_WIDTH = ipow_pkg::DATA_WIDTH_DEF,
    parameter int EXP_WIDTH  = ipow_pkg::EXP_WIDTH_DEF
) (
    input  logic                 clk,
    input  ipow_pkg::arg_t       args,
    input  ipow_pkg::ipow_cmd_t  cmd,
    output ipow_pkg::ipow_status_t status,
    output ipow_pkg::result_t    result
);
    import ipow_pkg::*;

    localparam int HALF_W = (DATA_WIDTH + 1) / 2;
    localparam int HI_W   = DATA_WIDTH - HALF_W;

    logic [DATA_WIDTH-1:0] x_in;
    logic [EXP_WIDTH-1:0]  y_in;
    logic                  x_neg_in;
    logic                  y_neg_in;
    logic                  y_odd_in;
    logic                  x_zero_in;
    logic [DATA_WIDTH-1:0] spec_val_in;

    logic [DATA_WIDTH-1:0] mag_reg;
    logic [DATA_WIDTH-1:0] res_reg;
    logic [EXP_WIDTH-1:0]  exp_reg;
    logic                  special_reg;
    logic [DATA_WIDTH-1:0] spec_val_reg;
    logic                  neg_fix_reg;
    logic                  zpz_reg;
    logic [2*HALF_W-1:0]   prod_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    result_t               result_reg;

    logic [DATA_WIDTH-1:0] op_full;
    logic [HALF_W-1:0]     a_lo;
    logic [HALF_W-1:0]     a_hi;
    logic [HALF_W-1:0]     b_lo;
    logic [HALF_W-1:0]     b_hi;
    logic [HALF_W-1:0]     op_a;
    logic [HALF_W-1:0]     op_b;
    logic [2*HALF_W-1:0]   mult;
    logic [DATA_WIDTH-1:0] prod_shifted;
    logic [DATA_WIDTH-1:0] acc_sum;
    logic [DATA_WIDTH-1:0] final_val;

    assign x_in      = args.base_value[DATA_WIDTH-1:0];
    assign y_in      = args.exponent[EXP_WIDTH-1:0];
    assign x_neg_in  = x_in[DATA_WIDTH-1];
    assign y_neg_in  = y_in[EXP_WIDTH-1];
    assign y_odd_in  = y_in[0];
    assign x_zero_in = (x_in == '0);

    // zero base gives zero; negative exponent leaves only the unit bases
    always_comb
    begin
        spec_val_in = '0;
        if (!x_zero_in && x_in == DATA_WIDTH'(1))
        begin
            spec_val_in = DATA_WIDTH'(1);
        end
        else if (!x_zero_in && x_in == '1)
        begin
            spec_val_in = y_odd_in ? '1 : DATA_WIDTH'(1);
        end
    end

    assign op_full = cmd.dst_res ? res_reg : mag_reg;
    assign a_lo    = op_full[HALF_W-1:0];
    assign a_hi    = HALF_W'(op_full[DATA_WIDTH-1:HALF_W]);
    assign b_lo    = mag_reg[HALF_W-1:0];
    assign b_hi    = HALF_W'(mag_reg[DATA_WIDTH-1:HALF_W]);
    assign op_a    = (cmd.phase == PH_HI_LO) ? a_hi : a_lo;
    assign op_b    = (cmd.phase == PH_LO_HI) ? b_hi : b_lo;
    assign mult    = (2*HALF_W)'(op_a) * (2*HALF_W)'(op_b);

    // cross products only reach the upper half of the wrapped word
    assign prod_shifted = {prod_reg[HI_W-1:0], {HALF_W{1'b0}}};
    assign acc_sum      = acc_reg + prod_shifted;

    assign final_val = special_reg ? spec_val_reg :
                       (neg_fix_reg ? (DATA_WIDTH'(0) - res_reg) : res_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg      <= x_neg_in ? (DATA_WIDTH'(0) - x_in) : x_in;
            res_reg      <= DATA_WIDTH'(1);
            exp_reg      <= y_in;
            special_reg  <= x_zero_in | y_neg_in;
            spec_val_reg <= spec_val_in;
            neg_fix_reg  <= x_neg_in & y_odd_in;
            zpz_reg      <= x_zero_in & (y_in == '0);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mult;
            case (cmd.phase)
                PH_LO_LO: acc_reg <= acc_reg;
                PH_LO_HI: acc_reg <= prod_reg[DATA_WIDTH-1:0];
                PH_HI_LO: acc_reg <= acc_sum;
                PH_WRITE:
                begin
                    if (cmd.dst_res)
                    begin
                        res_reg <= acc_sum;
                    end
                    else
                    begin
                        mag_reg <= acc_sum;
                    end
                end
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.shift_exp)
        begin
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.finish)
        begin
            result_reg.power         <= DATA_W_MAX'(final_val);
            result_reg.zero_pow_zero <= zpz_reg;
        end
    end

    assign status.special  = special_reg;
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign result          = result_reg;

endmodule

// File: hdl/ipow_ctrl.sv
`timescale 1ns / 1ps

module ipow_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ipow_pkg::ipow_status_t status,
    output ipow_pkg::ipow_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);
    import ipow_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_MUL    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    mul_phase_t phase_reg;
    mul_phase_t phase_next;
    logic       dst_res_reg;
    logic       dst_res_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        dst_res_next  = dst_res_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.phase     = phase_reg;
        cmd.dst_res   = dst_res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.special || status.exp_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    // multiply into the result first when this exponent bit is set
                    state_next   = S_MUL;
                    phase_next   = PH_LO_LO;
                    dst_res_next = status.exp_lsb;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (phase_reg != PH_WRITE)
                begin
                    phase_next = mul_phase_t'(phase_reg + 2'd1);
                end
                else
                begin
                    phase_next = PH_LO_LO;
                    if (dst_res_reg)
                    begin
                        dst_res_next = 1'b0;
                    end
                    else
                    begin
                        cmd.shift_exp = 1'b1;
                        state_next    = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_LO_LO;
            dst_res_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            dst_res_reg <= dst_res_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: hdl/integer_power_by_squaring.sv
`timescale 1ns / 1ps

// Integer power, base^exponent with wrap-around: a transaction is taken when start is
// high and busy is low, and its result appears on result with done high for exactly one
// cycle; the receiver cannot stall it, so it must capture result on that cycle.
// Zero base, negative exponent and zero exponent finish without any multiply. Otherwise
// the work is done by a single half-width multiplier that builds each wrapped product
// from three partial products, one squaring per exponent bit up to the highest set bit
// plus one multiply per set bit. busy stays high until the result is out.
module integer_power_by_squaring #(
    parameter int DATA_WIDTH = ipow_pkg::DATA_WIDTH_DEF,
    parameter int EXP_WIDTH  = ipow_pkg::EXP_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ipow_pkg::arg_t    args,
    output logic              done,
    output ipow_pkg::result_t result
);
    import ipow_pkg::*;

    ipow_cmd_t    cmd;
    ipow_status_t status;

    ipow_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ipow_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .args   (args),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ipow_pkg::*;

    localparam int          DATA_WIDTH  = 64;
    localparam int          EXP_WIDTH   = 32;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          DRAIN_WAIT  = 300;
    localparam logic [63:0] BASE_MIN    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] BASE_MAX    = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINUS_ONE   = 64'hffff_ffff_ffff_ffff;
    localparam logic [31:0] EXP_MIN     = 32'h8000_0000;
    localparam logic [31:0] EXP_MAX     = 32'h7fff_ffff;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    arg_t    args;
    logic    done;
    result_t result;

    result_t pending_powers[$];
    int      mismatches;
    int      cycles;
    int      idle_pct;

    integer_power_by_squaring #(
        .DATA_WIDTH (DATA_WIDTH),
        .EXP_WIDTH  (EXP_WIDTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .args   (args),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // base^exponent with Fortran rules, products wrapping at 64 bits
    function automatic result_t predict_power(input logic [63:0] b, input logic [31:0] e);
        result_t     r;
        logic [63:0] mag;
        logic [63:0] acc;
        logic [31:0] bits;
        r.power         = '0;
        r.zero_pow_zero = 1'b0;
        if (b == 64'd0)
        begin
            r.zero_pow_zero = (e == 32'd0);
        end
        else if (e[EXP_WIDTH-1])
        begin
            if (b == 64'd1)
                r.power = 64'd1;
            else if (b == MINUS_ONE)
                r.power = e[0] ? MINUS_ONE : 64'd1;
        end
        else if (e == 32'd0)
        begin
            r.power = 64'd1;
        end
        else
        begin
            mag  = b[DATA_WIDTH-1] ? -b : b;
            acc  = 64'd1;
            bits = e;
            for (int k = 0; k < EXP_WIDTH - 1; k++)
            begin
                if (bits[0])
                    acc = acc * mag;
                mag  = mag * mag;
                bits = bits >> 1;
            end
            if (b[DATA_WIDTH-1] && e[0])
                acc = -acc;
            r.power = acc;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // holds start high until the transaction is taken, with a random idle stretch first
    task automatic send_args(input logic [63:0] b, input logic [31:0] e);
        arg_t a;
        a.base_value = b;
        a.exponent   = e;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        args  <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_powers.push_back(predict_power(b, e));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result power=%0d",
                                          $signed(result.power)));
            end
            else
            begin
                want = pending_powers.pop_front();
                if (result.power !== want.power)
                    report_mismatch($sformatf("power %0d, expected %0d",
                                              $signed(result.power), $signed(want.power)));
                if (result.zero_pow_zero !== want.zero_pow_zero)
                    report_mismatch($sformatf("zero_pow_zero %b, expected %b",
                                              result.zero_pow_zero, want.zero_pow_zero));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // zero base, negative exponents, zero exponent and the unit bases
    task automatic test_special_cases();
        send_args(64'd0, 32'd0);
        send_args(64'd0, 32'd5);
        send_args(64'd0, MINUS_ONE[31:0]);
        send_args(64'd0, EXP_MIN);
        send_args(64'd1, -32'sd7);
        send_args(MINUS_ONE, -32'sd3);
        send_args(MINUS_ONE, -32'sd4);
        send_args(64'd5, MINUS_ONE[31:0]);
        send_args(BASE_MAX, EXP_MIN);
        send_args(64'd7, 32'd0);
        send_args(BASE_MIN, 32'd0);
    endtask

    // field extremes, most negative base and wrapping products
    task automatic test_extremes();
        send_args(BASE_MAX, EXP_MAX);
        send_args(BASE_MIN, 32'd1);
        send_args(BASE_MIN, 32'd2);
        send_args(BASE_MIN, 32'd63);
        send_args(BASE_MIN, EXP_MAX);
        send_args(64'd2, 32'd63);
        send_args(64'd2, 32'd64);
        send_args(MINUS_ONE, EXP_MAX);
        send_args(-64'sd3, 32'd3);
        send_args(64'd3, 32'd40);
        send_args(-64'sd2, 32'd62);
        send_args(64'hdead_beef_cafe_f00d, 32'h5555_5555);
    endtask

    task automatic test_random(input int count);
        logic [63:0] b;
        logic [31:0] e;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    case ($urandom_range(5))
                        0:       b = 64'd0;
                        1:       b = 64'd1;
                        2:       b = MINUS_ONE;
                        3:       b = BASE_MIN;
                        4:       b = BASE_MAX;
                        default: b = 64'd2;
                    endcase
                end
                1, 2:    b = 64'($signed($urandom_range(40)) - 20);
                default: b = {$urandom, $urandom};
            endcase
            case ($urandom_range(9))
                0:       e = {1'b1, 31'($urandom)};
                1:       e = 32'd0;
                2, 3, 4, 5: e = 32'($urandom_range(70));
                6, 7:    e = $urandom;
                default: e = {1'b0, 31'($urandom)} >> $urandom_range(31);
            endcase
            send_args(b, e);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        args       = '0;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 6;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_extremes();
        test_random(270);
        idle_pct = 84;
        test_random(270);
        idle_pct = 0;
        test_random(260);

        start <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
